// File: hdl/cubic_bezier_outline_flattener_defines.svh
// Assertion macros used by the flattener back end.
`ifndef CUBIC_BEZIER_OUTLINE_FLATTENER_DEFINES_SVH
`define CUBIC_BEZIER_OUTLINE_FLATTENER_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define CBOF_ASSERT_HOLD(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset.
`define CBOF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/cbof_pkg.sv
// Types, constants and helpers of the cubic Bezier outline flattener.
package cbof_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int MAX_STEPS   = 64;
    localparam int STEP_W      = 7;
    localparam int STEPS_RESET = 8;
    localparam int STEPS_MIN   = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int SQ_W  = $clog2(MAX_STEPS * MAX_STEPS + 1);
    localparam int DEN_W = $clog2(MAX_STEPS * MAX_STEPS * MAX_STEPS + 1);
    localparam int WGT_W = $clog2(3 * MAX_STEPS * MAX_STEPS * MAX_STEPS + 1);
    localparam int ACC_W = COORD_WIDTH + DEN_W + 1;
    localparam int QUO_W = COORD_WIDTH + 1;
    localparam int DCNT_W = $clog2(QUO_W + 1);

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef enum logic [1:0] {
        ACT_BEGIN  = 2'd0,
        ACT_CURVE  = 2'd1,
        ACT_CORNER = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef struct packed {
        action_t             action;
        coord_t              c1x;
        coord_t              c1y;
        coord_t              c2x;
        coord_t              c2y;
        coord_t              ex;
        coord_t              ey;
        logic                fin;
        logic [STEP_W-1:0]   n;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_WEIGHT1,
        ST_WEIGHT2,
        ST_ACC,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_EMIT
    } state_t;

    function automatic coord_t sat_coord(input logic signed [QUO_W:0] v);
        logic signed [QUO_W:0] hi;
        logic signed [QUO_W:0] lo;
        hi = (QUO_W+1)'((2 ** (COORD_WIDTH - 1)) - 1);
        lo = -hi - 1;
        if (v > hi) begin
            return hi[COORD_WIDTH-1:0];
        end else if (v < lo) begin
            return lo[COORD_WIDTH-1:0];
        end
        return v[COORD_WIDTH-1:0];
    endfunction

endpackage

// File: hdl/cbof_front.sv
// Front end: step-count register, input acceptance and item classification.
module cbof_front import cbof_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [STEP_W-1:0]   cfg_steps_per_curve,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_action,
    input  coord_t              s_first_ctrl_x,
    input  coord_t              s_first_ctrl_y,
    input  coord_t              s_second_ctrl_x,
    input  coord_t              s_second_ctrl_y,
    input  coord_t              s_end_x,
    input  coord_t              s_end_y,
    input  logic                s_final_segment,
    input  logic                q_full,
    output logic                q_push,
    output item_t               q_item
);

    logic [STEP_W-1:0] steps_reg;
    logic [STEP_W-1:0] steps_next;
    logic [STEP_W-1:0] n_eff;
    action_t           act;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;
    assign act       = action_t'(s_action);

    always_comb begin
        steps_next = steps_reg;
        if (cfg_valid) begin
            steps_next = cfg_steps_per_curve;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            steps_reg <= STEP_W'(STEPS_RESET);
        end else begin
            steps_reg <= steps_next;
        end
    end

    always_comb begin
        priority if (steps_reg < STEP_W'(STEPS_MIN)) begin
            n_eff = STEP_W'(STEPS_MIN);
        end else if (steps_reg > STEP_W'(MAX_STEPS)) begin
            n_eff = STEP_W'(MAX_STEPS);
        end else begin
            n_eff = steps_reg;
        end
    end

    // reserved action code is taken and dropped here
    assign q_push = s_valid && !q_full && (act != ACT_NONE);

    always_comb begin
        q_item.action = act;
        q_item.c1x    = s_first_ctrl_x;
        q_item.c1y    = s_first_ctrl_y;
        q_item.c2x    = s_second_ctrl_x;
        q_item.c2y    = s_second_ctrl_y;
        q_item.ex     = s_end_x;
        q_item.ey     = s_end_y;
        q_item.fin    = s_final_segment;
        q_item.n      = n_eff;
    end

endmodule

// File: hdl/cbof_queue.sv
// Short item queue between front and back.
module cbof_queue import cbof_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output item_t pop_item,
    output logic  full,
    output logic  empty
);

    item_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push;
    logic              do_pop;

    assign full     = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = mem_reg[rd_reg];

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push) begin
            wr_next = (wr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_next = (rd_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= push_item;
        end
    end

endmodule

// File: hdl/cbof_divider.sv
// Serial restoring divider: round-to-nearest signed quotient, saturated.
module cbof_divider import cbof_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [ACC_W-1:0] num,
    input  logic [DEN_W-1:0]        den,
    output logic                    done,
    output coord_t                  quotient
);

    logic signed [ACC_W-1:0] adj;
    logic [ACC_W-1:0]        mag;
    logic [DEN_W-1:0]        rem_reg, rem_next;
    logic [QUO_W-1:0]        quo_reg, quo_next;
    logic [DEN_W-1:0]        dsr_reg;
    logic                    neg_reg;
    logic                    busy_reg, busy_next;
    logic [DCNT_W-1:0]       cnt_reg, cnt_next;
    logic                    done_reg;
    logic [DEN_W:0]          partial;
    logic [DEN_W:0]          diff;
    logic                    fits;
    logic signed [QUO_W:0]   qs;
    logic signed [QUO_W:0]   qf;

    // floor(num/den + 1/2): bias by half the divisor, then floor-divide
    assign adj = num + $signed({{(ACC_W-DEN_W+1){1'b0}}, den[DEN_W-1:1]});
    assign mag = adj[ACC_W-1] ? ACC_W'(-adj) : adj;

    assign partial = {rem_reg, quo_reg[QUO_W-1]};
    assign diff    = partial - {1'b0, dsr_reg};
    assign fits    = (partial >= {1'b0, dsr_reg});

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start) begin
            // quotient stays below 2^QUO_W, so the top bits are below den
            rem_next  = mag[ACC_W-1:QUO_W];
            quo_next  = mag[QUO_W-1:0];
            busy_next = 1'b1;
            cnt_next  = DCNT_W'(QUO_W);
        end else if (busy_reg) begin
            rem_next = fits ? diff[DEN_W-1:0] : partial[DEN_W-1:0];
            quo_next = {quo_reg[QUO_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DCNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= busy_reg && (cnt_reg == DCNT_W'(1));
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start) begin
            dsr_reg <= den;
            neg_reg <= adj[ACC_W-1];
        end
    end

    assign qs = $signed({1'b0, quo_reg});

    always_comb begin
        if (!neg_reg) begin
            qf = qs;
        end else if (rem_reg != '0) begin
            qf = -(qs + 1'b1);
        end else begin
            qf = -qs;
        end
    end

    assign done     = done_reg;
    assign quotient = sat_coord(qf);

endmodule

// File: hdl/cbof_back.sv
// Back end: start-point state, cubic sampling sequencer and output register.
`include "cubic_bezier_outline_flattener_defines.svh"
module cbof_back import cbof_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    q_empty,
    input  item_t   q_item,
    output logic    q_pop,
    output logic    m_valid,
    input  logic    m_ready,
    output coord_t  m_vertex_x,
    output coord_t  m_vertex_y,
    output logic    m_last_of_run,
    output logic    m_outline_closed
);

    state_t                  state_reg, state_next;
    item_t                   item_reg, item_next;
    coord_t                  start_x_reg, start_x_next;
    coord_t                  start_y_reg, start_y_next;
    logic [STEP_W-1:0]       s_reg, s_next;
    logic [SQ_W-1:0]         n2_reg, n2_next;
    logic [DEN_W-1:0]        den_reg, den_next;
    logic [SQ_W-1:0]         u2_reg, u2_next;
    logic [SQ_W-1:0]         s2_reg, s2_next;
    logic [WGT_W-1:0]        w_reg [4];
    logic [WGT_W-1:0]        w_next [4];
    logic [1:0]              k_reg, k_next;
    logic signed [ACC_W-1:0] acc_x_reg, acc_x_next;
    logic signed [ACC_W-1:0] acc_y_reg, acc_y_next;
    logic                    phase_reg, phase_next;
    coord_t                  pend_x_reg, pend_x_next;
    coord_t                  pend_y_reg, pend_y_next;
    logic                    pend_last_reg, pend_last_next;
    logic                    pend_closed_reg, pend_closed_next;
    logic                    m_valid_reg, m_valid_next;
    coord_t                  m_x_reg, m_y_reg;
    logic                    m_last_reg, m_closed_reg;
    logic                    out_load;
    logic                    out_free;
    logic                    div_start;
    logic                    div_x_done, div_y_done;
    coord_t                  div_x_q, div_y_q;

    logic [STEP_W-1:0]             u;
    logic [2*STEP_W-1:0]           sq_n, sq_u, sq_s;
    logic [SQ_W+STEP_W-1:0]        cube_n, t_u3, t_u2s, t_us2, t_s3;
    logic [SQ_W+STEP_W:0]          w1_sum, w2_sum;
    coord_t                        p_x, p_y;
    logic signed [WGT_W+COORD_WIDTH:0] prod_x, prod_y;

    assign u      = item_reg.n - s_reg;
    assign sq_n   = item_reg.n * item_reg.n;
    assign sq_u   = u * u;
    assign sq_s   = s_reg * s_reg;
    assign cube_n = n2_reg * item_reg.n;
    assign t_u3   = u2_reg * u;
    assign t_u2s  = u2_reg * s_reg;
    assign t_us2  = s2_reg * u;
    assign t_s3   = s2_reg * s_reg;
    assign w1_sum = {1'b0, t_u2s} + {t_u2s, 1'b0};
    assign w2_sum = {1'b0, t_us2} + {t_us2, 1'b0};

    always_comb begin
        unique case (k_reg)
            2'd0: begin p_x = start_x_reg;  p_y = start_y_reg;  end
            2'd1: begin p_x = item_reg.c1x; p_y = item_reg.c1y; end
            2'd2: begin p_x = item_reg.c2x; p_y = item_reg.c2y; end
            2'd3: begin p_x = item_reg.ex;  p_y = item_reg.ey;  end
            default: begin p_x = item_reg.ex; p_y = item_reg.ey; end
        endcase
    end

    assign prod_x = $signed({1'b0, w_reg[k_reg]}) * p_x;
    assign prod_y = $signed({1'b0, w_reg[k_reg]}) * p_y;

    assign out_free = !m_valid_reg || m_ready;
    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;

    always_comb begin
        state_next       = state_reg;
        item_next        = item_reg;
        start_x_next     = start_x_reg;
        start_y_next     = start_y_reg;
        s_next           = s_reg;
        n2_next          = n2_reg;
        den_next         = den_reg;
        u2_next          = u2_reg;
        s2_next          = s2_reg;
        w_next           = w_reg;
        k_next           = k_reg;
        acc_x_next       = acc_x_reg;
        acc_y_next       = acc_y_reg;
        phase_next       = phase_reg;
        pend_x_next      = pend_x_reg;
        pend_y_next      = pend_y_reg;
        pend_last_next   = pend_last_reg;
        pend_closed_next = pend_closed_reg;
        out_load         = 1'b0;
        div_start        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    item_next  = q_item;
                    phase_next = 1'b0;
                    unique case (q_item.action)
                        ACT_BEGIN: begin
                            pend_x_next      = q_item.ex;
                            pend_y_next      = q_item.ey;
                            pend_last_next   = 1'b1;
                            pend_closed_next = 1'b0;
                            state_next       = ST_EMIT;
                        end
                        ACT_CORNER: begin
                            pend_x_next      = q_item.c2x;
                            pend_y_next      = q_item.c2y;
                            pend_last_next   = 1'b0;
                            pend_closed_next = 1'b0;
                            state_next       = ST_EMIT;
                        end
                        ACT_CURVE: begin
                            s_next     = STEP_W'(1);
                            state_next = ST_SETUP;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SETUP: begin
                n2_next    = sq_n[SQ_W-1:0];
                state_next = ST_WEIGHT1;
            end
            ST_WEIGHT1: begin
                den_next   = cube_n[DEN_W-1:0];
                u2_next    = sq_u[SQ_W-1:0];
                s2_next    = sq_s[SQ_W-1:0];
                state_next = ST_WEIGHT2;
            end
            ST_WEIGHT2: begin
                // Bernstein weights scaled by n^3
                w_next[0]  = t_u3[WGT_W-1:0];
                w_next[1]  = w1_sum[WGT_W-1:0];
                w_next[2]  = w2_sum[WGT_W-1:0];
                w_next[3]  = t_s3[WGT_W-1:0];
                k_next     = 2'd0;
                acc_x_next = '0;
                acc_y_next = '0;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                acc_x_next = acc_x_reg + $signed(prod_x[ACC_W-1:0]);
                acc_y_next = acc_y_reg + $signed(prod_y[ACC_W-1:0]);
                k_next     = k_reg + 1'b1;
                if (k_reg == 2'd3) begin
                    state_next = ST_DIV_GO;
                end
            end
            ST_DIV_GO: begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_x_done) begin
                    pend_x_next      = div_x_q;
                    pend_y_next      = div_y_q;
                    pend_last_next   = (s_reg == item_reg.n);
                    pend_closed_next = (s_reg == item_reg.n) && item_reg.fin;
                    state_next       = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    priority if ((item_reg.action == ACT_CORNER) && !phase_reg) begin
                        pend_x_next      = item_reg.ex;
                        pend_y_next      = item_reg.ey;
                        pend_last_next   = 1'b1;
                        pend_closed_next = item_reg.fin;
                        phase_next       = 1'b1;
                    end else if ((item_reg.action == ACT_CURVE) && (s_reg != item_reg.n)) begin
                        s_next     = s_reg + 1'b1;
                        state_next = ST_WEIGHT1;
                    end else begin
                        start_x_next = item_reg.ex;
                        start_y_next = item_reg.ey;
                        state_next   = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        m_valid_next = m_valid_reg && !m_ready;
        if (out_load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            start_x_reg <= '0;
            start_y_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            start_x_reg <= start_x_next;
            start_y_reg <= start_y_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg        <= item_next;
        s_reg           <= s_next;
        n2_reg          <= n2_next;
        den_reg         <= den_next;
        u2_reg          <= u2_next;
        s2_reg          <= s2_next;
        w_reg           <= w_next;
        k_reg           <= k_next;
        acc_x_reg       <= acc_x_next;
        acc_y_reg       <= acc_y_next;
        phase_reg       <= phase_next;
        pend_x_reg      <= pend_x_next;
        pend_y_reg      <= pend_y_next;
        pend_last_reg   <= pend_last_next;
        pend_closed_reg <= pend_closed_next;
        if (out_load) begin
            m_x_reg      <= pend_x_reg;
            m_y_reg      <= pend_y_reg;
            m_last_reg   <= pend_last_reg;
            m_closed_reg <= pend_closed_reg;
        end
    end

    cbof_divider u_div_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .num      (acc_x_reg),
        .den      (den_reg),
        .done     (div_x_done),
        .quotient (div_x_q)
    );

    cbof_divider u_div_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .num      (acc_y_reg),
        .den      (den_reg),
        .done     (div_y_done),
        .quotient (div_y_q)
    );

    assign m_valid          = m_valid_reg;
    assign m_vertex_x       = m_x_reg;
    assign m_vertex_y       = m_y_reg;
    assign m_last_of_run    = m_last_reg;
    assign m_outline_closed = m_closed_reg;

    `CBOF_ASSERT_HOLD(a_div_lockstep, state_reg == ST_DIV_WAIT, div_x_done == div_y_done, "x and y dividers out of step")
    `CBOF_ASSERT_HOLD(a_acc_curve_only, state_reg == ST_ACC, item_reg.action == ACT_CURVE, "accumulate outside a curve")
    `CBOF_ASSERT_HOLD(a_step_range, (state_reg != ST_IDLE) && (item_reg.action == ACT_CURVE), (s_reg != '0) && (s_reg <= item_reg.n), "sample index out of range")
    `CBOF_ASSERT_NEXT(a_pop_leaves_idle, q_pop, state_reg != ST_IDLE, "popped word not started")

endmodule

// File: hdl/cubic_bezier_outline_flattener.sv
// Cubic Bezier outline flattener: top level.
// Usage:
//   cfg channel (cfg_valid/cfg_ready/cfg_steps_per_curve) sets the samples
//   per curve; write it only while the block is idle. cfg_ready is always 1.
//   s_ channel takes one segment word: begin, curve or corner. The front
//   end queues up to two words, so s_ready drops only when that queue fills.
//   m_ channel returns vertices; last_of_run marks the last vertex of a word.
// Vertices per word:
//   begin word: one vertex, its end point.
//   corner word: two vertices, one per cycle while m_ready is high.
//   curve word with n samples: n vertices; each sample takes the weight
//   steps, a multiply-accumulate step per control point and a serial
//   divide by n^3 (x and y in parallel), which sets the rate.
// Reset: aresetn low clears the start point to 0, the step count to 8,
//   the queue and the output valid flag.
// Stall: m_ready held low keeps the output word in place; the sequencer waits
//   with the next vertex and the queue keeps taking input until it is full.
module cubic_bezier_outline_flattener import cbof_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [STEP_W-1:0]   cfg_steps_per_curve,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_action,
    input  coord_t              s_first_ctrl_x,
    input  coord_t              s_first_ctrl_y,
    input  coord_t              s_second_ctrl_x,
    input  coord_t              s_second_ctrl_y,
    input  coord_t              s_end_x,
    input  coord_t              s_end_y,
    input  logic                s_final_segment,
    output logic                m_valid,
    input  logic                m_ready,
    output coord_t              m_vertex_x,
    output coord_t              m_vertex_y,
    output logic                m_last_of_run,
    output logic                m_outline_closed
);

    logic  q_push;
    logic  q_pop;
    logic  q_full;
    logic  q_empty;
    item_t push_item;
    item_t pop_item;

    cbof_front u_front (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_steps_per_curve (cfg_steps_per_curve),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_action            (s_action),
        .s_first_ctrl_x      (s_first_ctrl_x),
        .s_first_ctrl_y      (s_first_ctrl_y),
        .s_second_ctrl_x     (s_second_ctrl_x),
        .s_second_ctrl_y     (s_second_ctrl_y),
        .s_end_x             (s_end_x),
        .s_end_y             (s_end_y),
        .s_final_segment     (s_final_segment),
        .q_full              (q_full),
        .q_push              (q_push),
        .q_item              (push_item)
    );

    cbof_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    cbof_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_empty          (q_empty),
        .q_item           (pop_item),
        .q_pop            (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_vertex_x       (m_vertex_x),
        .m_vertex_y       (m_vertex_y),
        .m_last_of_run    (m_last_of_run),
        .m_outline_closed (m_outline_closed)
    );

endmodule
